/* hdl/bbps_pkg.sv */
// ----------------------------------------------------------------------------
// bbps_pkg
// Shared types, constants and helper functions for the ball physics step.
// ----------------------------------------------------------------------------
package bbps_pkg;

    typedef logic signed [31:0] t_q;

    typedef struct packed {
        logic [24:0] play_speed;
        logic [23:0] world_half_x;
        logic [23:0] world_half_y;
    } t_cfg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PLAY_SPEED   = 2'd0;
    localparam logic [1:0] CFG_WORLD_HALF_X = 2'd1;
    localparam logic [1:0] CFG_WORLD_HALF_Y = 2'd2;

    localparam logic [24:0] RST_PLAY_SPEED   = 25'd65536;
    localparam logic [23:0] RST_WORLD_HALF_X = 24'd1310720;
    localparam logic [23:0] RST_WORLD_HALF_Y = 24'd655360;

    localparam t_q          Q_ONE      = 32'sd65536;
    localparam t_q          Q_GRAV     = 32'sd642253;
    localparam t_q          Q_DAMP     = 32'sd58982;
    localparam t_q          Q_HALF     = 32'sd32768;
    localparam t_q          Q_MAX      = 32'sh7fffffff;
    localparam t_q          Q_MIN      = 32'sh80000000;
    localparam logic [22:0] MAX_STEP_Q = 23'd3276800;

    localparam t_q RST_VEL_X = 32'sd131072;
    localparam t_q RST_SPIN  = 32'sd1310720;

    // Clamp a wide signed value to the 32-bit range.
    function automatic t_q sat37(input logic signed [36:0] v);
        t_q r;
        if (v > 37'(Q_MAX)) begin
            r = Q_MAX;
        end else if (v < 37'(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Negation where the most negative value turns into the largest one.
    function automatic t_q sat_neg(input t_q v);
        t_q r;
        if (v == Q_MIN) begin
            r = Q_MAX;
        end else begin
            r = -v;
        end
        return r;
    endfunction

    // Speeds with a magnitude below one half are treated as rest.
    function automatic t_q small_to_zero(input t_q v);
        t_q r;
        if (v > -Q_HALF && v < Q_HALF) begin
            r = '0;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* hdl/bbps_if.sv */
// ----------------------------------------------------------------------------
// bbps interfaces
// Valid/ready channels for requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface bbps_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [22:0] time_step;
    logic [2:0]  launch_speed;

    modport source (output valid, req_type, time_step, launch_speed, input ready);
    modport sink   (input valid, req_type, time_step, launch_speed, output ready);
endinterface

interface bbps_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] ang_x;
    logic signed [31:0] ang_y;
    logic signed [31:0] ang_z;

    modport source (output valid, pos_x, pos_y, pos_z, ang_x, ang_y, ang_z,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, ang_x, ang_y, ang_z,
                    output ready);
endinterface

interface bbps_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [24:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/bbps_mul.sv */
// ----------------------------------------------------------------------------
// bbps_mul
// Shared signed 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module bbps_mul (
    input  logic               i_clk,
    input  bbps_pkg::t_q       i_a,
    input  bbps_pkg::t_q       i_b,
    output logic signed [63:0] o_p
);

    logic signed [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

/* hdl/bbps_cfg.sv */
// ----------------------------------------------------------------------------
// bbps_cfg
// Configuration register bank; writes are always taken.
// ----------------------------------------------------------------------------
module bbps_cfg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bbps_cfg_if.sink         i_cfg,
    output bbps_pkg::t_cfg   o_cfg
);

    bbps_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.play_speed   <= bbps_pkg::RST_PLAY_SPEED;
            r_cfg.world_half_x <= bbps_pkg::RST_WORLD_HALF_X;
            r_cfg.world_half_y <= bbps_pkg::RST_WORLD_HALF_Y;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bbps_pkg::CFG_PLAY_SPEED:   r_cfg.play_speed   <= i_cfg.data;
                bbps_pkg::CFG_WORLD_HALF_X: r_cfg.world_half_x <= i_cfg.data[23:0];
                bbps_pkg::CFG_WORLD_HALF_Y: r_cfg.world_half_y <= i_cfg.data[23:0];
                default: ;
            endcase
        end
    end

endmodule

/* hdl/bouncing_ball_physics_step_core.sv */
// ----------------------------------------------------------------------------
// bouncing_ball_physics_step_core
// One physics step of a bouncing, spinning ball in signed Q16.16 arithmetic.
// ----------------------------------------------------------------------------
// Usage: a request transaction on i_req is either a time tick (req_type 0,
// carrying time_step) or a restart (req_type 1, carrying launch_speed). Every
// request yields exactly one result transaction on o_res with the position and
// angle of the ball after the request. Configuration transactions on i_cfg are
// always accepted and should only be issued while no request is in flight.
// All products go through one registered 32x32 multiplier under a sequencer,
// so a tick runs the move products, the floor test, the six extra damping
// products when the ball hits the floor, and the wall test. Restarts and
// ignored ticks go straight to the result hand-off. i_req is ready only while
// the sequencer is idle, and it returns to idle on the edge that loads the
// result, so a new request is accepted only once the previous one has been
// handed to the output register.
// The result sits in its own output register: a new request is accepted while
// the previous result waits, and the sequencer holds its finished result only
// when the output register is still occupied by a stalled receiver.
// Reset (synchronous, active low) restores the default registers and places
// the ball at the top-left launch point with a speed of two.
// ----------------------------------------------------------------------------
module bouncing_ball_physics_step_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bbps_req_if.sink    i_req,
    bbps_res_if.source  o_res,
    bbps_cfg_if.sink    i_cfg
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOVE  = 3'd1;
    localparam logic [2:0] S_FLOOR = 3'd2;
    localparam logic [2:0] S_DAMP  = 3'd3;
    localparam logic [2:0] S_WALL  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    bbps_pkg::t_cfg     cfg;
    bbps_pkg::t_q       mul_a;
    bbps_pkg::t_q       mul_b;
    logic signed [63:0] prod;

    logic [2:0]   r_state, n_state;
    logic [3:0]   r_op, n_op;
    logic [22:0]  r_step, n_step;
    logic [30:0]  r_k, n_k;
    logic         r_hit, n_hit;
    logic         r_out_valid, n_out_valid;

    bbps_pkg::t_q r_pos  [3];
    bbps_pkg::t_q n_pos  [3];
    bbps_pkg::t_q r_ang  [3];
    bbps_pkg::t_q n_ang  [3];
    bbps_pkg::t_q r_vel  [3];
    bbps_pkg::t_q n_vel  [3];
    bbps_pkg::t_q r_spin [3];
    bbps_pkg::t_q n_spin [3];
    bbps_pkg::t_q r_out_pos [3];
    bbps_pkg::t_q n_out_pos [3];
    bbps_pkg::t_q r_out_ang [3];
    bbps_pkg::t_q n_out_ang [3];

    // Geometry derived from the configuration.
    logic signed [32:0] floor_y;
    logic signed [32:0] wall;
    logic signed [32:0] pos_y33;
    logic signed [32:0] pos_x33;
    logic               floor_hit;
    logic               wall_hit;
    bbps_pkg::t_q       start_x;
    bbps_pkg::t_q       start_y;
    bbps_pkg::t_q       launch_vel;
    bbps_pkg::t_q       launch_spin;
    logic signed [36:0] vy_grav;
    bbps_pkg::t_q       delta;

    bbps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    bbps_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign floor_y   = 33'(bbps_pkg::Q_ONE) - $signed({9'b0, cfg.world_half_y});
    assign wall      = $signed({9'b0, cfg.world_half_x}) - 33'(bbps_pkg::Q_ONE);
    assign pos_y33   = 33'(r_pos[1]);
    assign pos_x33   = 33'(r_pos[0]);
    assign floor_hit = (pos_y33 <= floor_y);
    assign wall_hit  = (pos_x33 >= wall) || (pos_x33 <= -wall);

    assign start_x = bbps_pkg::Q_ONE - $signed({8'b0, cfg.world_half_x});
    assign start_y = $signed({8'b0, cfg.world_half_y}) - bbps_pkg::Q_ONE;

    // Launch speed as Q16.16, and ten times it for the spin (8x plus 2x).
    assign launch_vel  = $signed({13'b0, i_req.launch_speed, 16'b0});
    assign launch_spin = $signed({10'b0, i_req.launch_speed, 19'b0})
                       + $signed({12'b0, i_req.launch_speed, 17'b0});

    // Gravity product is never negative, so its floor is a plain shift.
    assign vy_grav = 37'(r_vel[1]) - $signed({2'b0, prod[50:16]});
    // Floor of a Q16.16 product, kept to 32 bits.
    assign delta   = $signed(prod[47:16]);

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.pos_x = r_out_pos[0];
    assign o_res.pos_y = r_out_pos[1];
    assign o_res.pos_z = r_out_pos[2];
    assign o_res.ang_x = r_out_ang[0];
    assign o_res.ang_y = r_out_ang[1];
    assign o_res.ang_z = r_out_ang[2];

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_step      = r_step;
        n_k         = r_k;
        n_hit       = r_hit;
        n_out_valid = r_out_valid;
        n_pos       = r_pos;
        n_ang       = r_ang;
        n_vel       = r_vel;
        n_spin      = r_spin;
        n_out_pos   = r_out_pos;
        n_out_ang   = r_out_ang;
        mul_a       = '0;
        mul_b       = '0;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.req_type) begin
                        // Restart keeps the angle and relaunches from the corner.
                        n_pos[0]  = start_x;
                        n_pos[1]  = start_y;
                        n_pos[2]  = '0;
                        n_vel[0]  = launch_vel;
                        n_vel[1]  = '0;
                        n_vel[2]  = '0;
                        n_spin[0] = launch_spin;
                        n_spin[1] = launch_spin;
                        n_spin[2] = launch_spin;
                        n_state   = S_DONE;
                    end else if (i_req.time_step == '0 ||
                                 i_req.time_step > bbps_pkg::MAX_STEP_Q) begin
                        n_state = S_DONE;
                    end else begin
                        n_step  = i_req.time_step;
                        n_op    = '0;
                        n_state = S_MOVE;
                    end
                end
            end

            S_MOVE: begin
                // Issue product r_op while writing back product r_op - 1.
                case (r_op)
                    4'd0: begin
                        mul_a = $signed({9'b0, r_step});
                        mul_b = $signed({7'b0, cfg.play_speed});
                    end
                    4'd1: begin
                        mul_a = bbps_pkg::Q_GRAV;
                        mul_b = $signed({1'b0, prod[46:16]});
                    end
                    4'd2: begin mul_a = r_vel[0];  mul_b = $signed({1'b0, r_k}); end
                    4'd3: begin mul_a = r_vel[1];  mul_b = $signed({1'b0, r_k}); end
                    4'd4: begin mul_a = r_vel[2];  mul_b = $signed({1'b0, r_k}); end
                    4'd5: begin mul_a = r_spin[0]; mul_b = $signed({1'b0, r_k}); end
                    4'd6: begin mul_a = r_spin[1]; mul_b = $signed({1'b0, r_k}); end
                    4'd7: begin mul_a = r_spin[2]; mul_b = $signed({1'b0, r_k}); end
                    default: ;
                endcase

                case (r_op)
                    4'd1: n_k      = prod[46:16];
                    4'd2: n_vel[1] = bbps_pkg::sat37(vy_grav);
                    4'd3: n_pos[0] = r_pos[0] + delta;
                    4'd4: n_pos[1] = r_pos[1] + delta;
                    4'd5: n_pos[2] = r_pos[2] + delta;
                    4'd6: n_ang[0] = r_ang[0] + delta;
                    4'd7: n_ang[1] = r_ang[1] + delta;
                    4'd8: n_ang[2] = r_ang[2] + delta;
                    default: ;
                endcase

                if (r_op == 4'd8) begin
                    n_state = S_FLOOR;
                end else begin
                    n_op = r_op + 4'd1;
                end
            end

            S_FLOOR: begin
                n_hit = floor_hit;
                if (floor_hit) begin
                    n_vel[1] = bbps_pkg::sat_neg(r_vel[1]);
                    n_pos[1] = floor_y[31:0];
                    n_op     = '0;
                    n_state  = S_DAMP;
                end else begin
                    n_state = S_WALL;
                end
            end

            S_DAMP: begin
                // Scale all velocity and spin components by 0.9.
                mul_b = bbps_pkg::Q_DAMP;
                case (r_op)
                    4'd0: mul_a = r_vel[0];
                    4'd1: mul_a = r_vel[1];
                    4'd2: mul_a = r_vel[2];
                    4'd3: mul_a = r_spin[0];
                    4'd4: mul_a = r_spin[1];
                    4'd5: mul_a = r_spin[2];
                    default: ;
                endcase

                case (r_op)
                    4'd1: n_vel[0]  = delta;
                    4'd2: n_vel[1]  = delta;
                    4'd3: n_vel[2]  = delta;
                    4'd4: n_spin[0] = delta;
                    4'd5: n_spin[1] = delta;
                    4'd6: n_spin[2] = delta;
                    default: ;
                endcase

                if (r_op == 4'd6) begin
                    n_state = S_WALL;
                end else begin
                    n_op = r_op + 4'd1;
                end
            end

            S_WALL: begin
                if (r_hit) begin
                    n_vel[1] = bbps_pkg::small_to_zero(r_vel[1]);
                end
                if (wall_hit) begin
                    n_vel[0] = bbps_pkg::small_to_zero(bbps_pkg::sat_neg(r_vel[0]));
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                // Hand the state to the output register once it is free.
                if (!r_out_valid || o_res.ready) begin
                    n_out_pos   = r_pos;
                    n_out_ang   = r_ang;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos[0]    <= bbps_pkg::Q_ONE - $signed({8'b0, bbps_pkg::RST_WORLD_HALF_X});
            r_pos[1]    <= $signed({8'b0, bbps_pkg::RST_WORLD_HALF_Y}) - bbps_pkg::Q_ONE;
            r_pos[2]    <= '0;
            r_ang[0]    <= '0;
            r_ang[1]    <= '0;
            r_ang[2]    <= '0;
            r_vel[0]    <= bbps_pkg::RST_VEL_X;
            r_vel[1]    <= '0;
            r_vel[2]    <= '0;
            r_spin[0]   <= bbps_pkg::RST_SPIN;
            r_spin[1]   <= bbps_pkg::RST_SPIN;
            r_spin[2]   <= bbps_pkg::RST_SPIN;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            r_ang       <= n_ang;
            r_vel       <= n_vel;
            r_spin      <= n_spin;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_step    <= n_step;
        r_k       <= n_k;
        r_out_pos <= n_out_pos;
        r_out_ang <= n_out_ang;
    end

endmodule

/* verif/bouncing_ball_physics_step_core_tb.sv */
// ----------------------------------------------------------------------------
// bouncing_ball_physics_step_core_tb
// Self-checking testbench for the ball physics step core. A short directed
// table covers ignored ticks, restarts, extreme launch speeds and steps, and
// velocity saturation. Random phases follow, each under its own register
// setting. Every accepted request is run through a fixed-point predictor of
// the ball, and every result transaction is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module bouncing_ball_physics_step_core_tb;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 4;
    localparam int PHASE_ITEMS     = 215;
    localparam int NUM_PHASES      = 6;
    localparam int SETTLE_CYCLES   = 30;
    localparam int PRESSURE_AT     = 200;
    localparam int PRESSURE_CYCLES = 400;
    localparam int MAX_REPORTS     = 10;
    localparam int TIMEOUT_TIME    = 20000000;

    // Restarts give a spin of ten times the launch speed on every axis.
    localparam longint SPIN_PER_SPEED = 10;

    // Register index with no register behind it; writes to it must be ignored.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef enum logic {
        REQ_TICK    = 1'b0,
        REQ_RESTART = 1'b1
    } t_req_kind;

    typedef enum logic [1:0] {
        ROW_TICK,
        ROW_RESTART,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        bbps_pkg::t_q pos_x;
        bbps_pkg::t_q pos_y;
        bbps_pkg::t_q pos_z;
        bbps_pkg::t_q ang_x;
        bbps_pkg::t_q ang_y;
        bbps_pkg::t_q ang_z;
    } t_pose;

    // One row of the directed table. The value is the time step of a tick,
    // the launch speed of a restart, or the data of a register write.
    typedef struct {
        t_row_kind   kind;
        logic [1:0]  index;
        logic [24:0] value;
        bit          typed;
        t_pose       pose;
    } t_row;

    // Pose right after reset: top-left launch point of the default world.
    localparam t_pose RESET_POSE = '{
        pos_x: -32'sd1245184,
        pos_y: 32'sd589824,
        pos_z: 32'sd0,
        ang_x: 32'sd0,
        ang_y: 32'sd0,
        ang_z: 32'sd0
    };

    logic clk = 1'b0;
    logic rst_n;

    bbps_req_if req_bus ();
    bbps_res_if res_bus ();
    bbps_cfg_if cfg_bus ();

    bouncing_ball_physics_step_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Predicted ball state. It mirrors the registers and the four state
    // vectors of the core and is advanced once per accepted request.
    // ------------------------------------------------------------------------
    bbps_pkg::t_cfg ball_cfg;
    bbps_pkg::t_q   ball_pos  [3];
    bbps_pkg::t_q   ball_ang  [3];
    bbps_pkg::t_q   ball_vel  [3];
    bbps_pkg::t_q   ball_spin [3];

    // Poses still owed by the core, oldest first.
    t_pose pending_poses [$];
    t_row  directed_rows [$];

    int mismatch_count = 0;
    int results_seen   = 0;
    int burst_left     = 0;

    // Q16.16 product, rounded toward minus infinity.
    function automatic longint qmul(input longint a, input longint b);
        longint p;
        p = a * b;
        return p >>> 16;
    endfunction

    // Velocities and spins saturate to the signed 32-bit range.
    function automatic bbps_pkg::t_q clamp_q(input longint v);
        if (v > longint'(bbps_pkg::Q_MAX)) begin
            return bbps_pkg::Q_MAX;
        end
        if (v < longint'(bbps_pkg::Q_MIN)) begin
            return bbps_pkg::Q_MIN;
        end
        return v[31:0];
    endfunction

    // A speed with magnitude below one half counts as rest.
    function automatic bbps_pkg::t_q zero_if_slow(input bbps_pkg::t_q v);
        if (v > -bbps_pkg::Q_HALF && v < bbps_pkg::Q_HALF) begin
            return '0;
        end
        return v;
    endfunction

    // Put the ball at the top-left corner of the current world with the given
    // speed along x. The angle is left alone.
    function automatic void launch_ball(input logic [2:0] speed);
        longint corner;
        int     i;
        corner      = longint'(bbps_pkg::Q_ONE) - longint'(ball_cfg.world_half_x);
        ball_pos[0] = corner[31:0];
        corner      = longint'(ball_cfg.world_half_y) - longint'(bbps_pkg::Q_ONE);
        ball_pos[1] = corner[31:0];
        ball_pos[2] = '0;
        ball_vel[0] = clamp_q(longint'(speed) * longint'(bbps_pkg::Q_ONE));
        ball_vel[1] = '0;
        ball_vel[2] = '0;
        for (i = 0; i < 3; i++) begin
            ball_spin[i] = clamp_q(longint'(speed) * SPIN_PER_SPEED
                                   * longint'(bbps_pkg::Q_ONE));
        end
    endfunction

    // Advance the predicted ball by one request and return the pose that the
    // core must report for it.
    function automatic t_pose step_ball(input t_req_kind kind, input logic [22:0] step,
                                        input logic [2:0] speed);
        logic [47:0] scaled;
        longint      k;
        longint      floor_y;
        longint      wall;
        longint      sum;
        int          i;
        t_pose       pose;
        if (kind == REQ_RESTART) begin
            launch_ball(speed);
        end else if (step != '0 && step <= bbps_pkg::MAX_STEP_Q) begin
            scaled = 48'(step) * 48'(ball_cfg.play_speed);
            k      = longint'(scaled[47:16]);
            // Gravity acts on the vertical velocity before the ball moves.
            ball_vel[1] = clamp_q(longint'(ball_vel[1])
                                  - qmul(longint'(bbps_pkg::Q_GRAV), k));
            for (i = 0; i < 3; i++) begin
                sum         = longint'(ball_pos[i]) + qmul(longint'(ball_vel[i]), k);
                ball_pos[i] = sum[31:0];
                sum         = longint'(ball_ang[i]) + qmul(longint'(ball_spin[i]), k);
                ball_ang[i] = sum[31:0];
            end
            // Floor bounce: reflect, damp everything, clamp to the floor.
            floor_y = longint'(bbps_pkg::Q_ONE) - longint'(ball_cfg.world_half_y);
            if (longint'(ball_pos[1]) <= floor_y) begin
                ball_vel[1] = clamp_q(-longint'(ball_vel[1]));
                for (i = 0; i < 3; i++) begin
                    ball_vel[i]  = clamp_q(qmul(longint'(ball_vel[i]),
                                                longint'(bbps_pkg::Q_DAMP)));
                    ball_spin[i] = clamp_q(qmul(longint'(ball_spin[i]),
                                                longint'(bbps_pkg::Q_DAMP)));
                end
                ball_pos[1] = floor_y[31:0];
                ball_vel[1] = zero_if_slow(ball_vel[1]);
            end
            // Side walls only reflect the horizontal velocity.
            wall = longint'(ball_cfg.world_half_x) - longint'(bbps_pkg::Q_ONE);
            if (longint'(ball_pos[0]) >= wall || longint'(ball_pos[0]) <= -wall) begin
                ball_vel[0] = zero_if_slow(clamp_q(-longint'(ball_vel[0])));
            end
        end
        pose.pos_x = ball_pos[0];
        pose.pos_y = ball_pos[1];
        pose.pos_z = ball_pos[2];
        pose.ang_x = ball_ang[0];
        pose.ang_y = ball_ang[1];
        pose.ang_z = ball_ang[2];
        return pose;
    endfunction

    function automatic string pose_text(input t_pose p);
        return $sformatf("pos=(%0d,%0d,%0d) ang=(%0d,%0d,%0d)",
                         p.pos_x, p.pos_y, p.pos_z, p.ang_x, p.ang_y, p.ang_z);
    endfunction

    function automatic void add_row(input t_row_kind kind, input logic [24:0] value,
                                    input bit typed = 1'b0, input t_pose pose = '0,
                                    input logic [1:0] index = '0);
        t_row row;
        row.kind  = kind;
        row.index = index;
        row.value = value;
        row.typed = typed;
        row.pose  = pose;
        directed_rows.push_back(row);
    endfunction

    // Time steps for the random part. Most are frame-sized so that the ball
    // flies, bounces and comes to rest; a few are long, zero, too long, or
    // take any value of the field.
    function automatic logic [22:0] pick_step();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return 23'($urandom_range(3276801, 8388607));
            2:       return 23'($urandom());
            3, 4:    return 23'($urandom_range(6554, 3276800));
            default: return 23'($urandom_range(1, 6553));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request side. The sender works in bursts: within a burst valid stays
    // high from one transaction to the next, and between bursts it drops for
    // a random number of cycles so that gaps land on every stage of the
    // core's sequencer. The prediction is taken at the accepting edge.
    // ------------------------------------------------------------------------
    task automatic offer_request(input t_req_kind kind, input logic [22:0] step,
                                 input logic [2:0] speed, input bit typed = 1'b0,
                                 input t_pose pose = '0);
        t_pose predicted;
        if (burst_left == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        req_bus.valid        <= 1'b1;
        req_bus.req_type     <= kind;
        req_bus.time_step    <= step;
        req_bus.launch_speed <= speed;
        do @(posedge clk); while (!req_bus.ready);
        predicted = step_ball(kind, step, speed);
        // Rows with a hand-written pose are checked against that pose, while
        // the predictor still advances so that later rows stay in step.
        pending_poses.push_back(typed ? pose : predicted);
    endtask

    // Stop offering requests and wait until every owed result has come back.
    // Each request yields exactly one result, so the core is idle then.
    task automatic drain_results();
        req_bus.valid <= 1'b0;
        burst_left = 0;
        while (pending_poses.size() != 0) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [24:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= data;
        do @(posedge clk); while (!cfg_bus.ready);
        case (index)
            bbps_pkg::CFG_PLAY_SPEED:   ball_cfg.play_speed   = data;
            bbps_pkg::CFG_WORLD_HALF_X: ball_cfg.world_half_x = data[23:0];
            bbps_pkg::CFG_WORLD_HALF_Y: ball_cfg.world_half_y = data[23:0];
            default:                    ;
        endcase
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side. Each result transaction is popped against the oldest
    // prediction. The same process drives ready: a stall mode is redrawn at
    // random (always ready, mostly ready, mostly stalled, alternating), rare
    // long holds come at random, and one long hold is forced once a couple of
    // hundred results have arrived. During that hold the sender keeps offering,
    // so the core fills up and stalls its input.
    // ------------------------------------------------------------------------
    initial begin
        t_pose got_pose;
        t_pose want_pose;
        int    hold_cycles;
        int    mode_cycles;
        int    stall_mode;
        bit    pressure_done;
        hold_cycles   = 0;
        mode_cycles   = 0;
        stall_mode    = 0;
        pressure_done = 1'b0;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_bus.valid && res_bus.ready) begin
                got_pose = '{res_bus.pos_x, res_bus.pos_y, res_bus.pos_z,
                             res_bus.ang_x, res_bus.ang_y, res_bus.ang_z};
                if (pending_poses.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("Result transaction with none expected: %s",
                                 pose_text(got_pose));
                    end
                end else begin
                    want_pose = pending_poses.pop_front();
                    if (got_pose.pos_x !== want_pose.pos_x ||
                        got_pose.pos_y !== want_pose.pos_y ||
                        got_pose.pos_z !== want_pose.pos_z ||
                        got_pose.ang_x !== want_pose.ang_x ||
                        got_pose.ang_y !== want_pose.ang_y ||
                        got_pose.ang_z !== want_pose.ang_z) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("Pose mismatch on result %0d: expected %s, got %s",
                                     results_seen, pose_text(want_pose),
                                     pose_text(got_pose));
                        end
                    end
                end
                results_seen++;
            end

            if (!rst_n) begin
                res_bus.ready <= 1'b0;
            end else if (hold_cycles != 0) begin
                hold_cycles--;
                res_bus.ready <= 1'b0;
            end else if (!pressure_done && results_seen >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                hold_cycles   = PRESSURE_CYCLES;
                res_bus.ready <= 1'b0;
            end else if ($urandom_range(0, 1999) == 0) begin
                hold_cycles = $urandom_range(100, 300);
                res_bus.ready <= 1'b0;
            end else begin
                if (mode_cycles == 0) begin
                    stall_mode  = $urandom_range(0, 3);
                    mode_cycles = $urandom_range(20, 120);
                end else begin
                    mode_cycles--;
                end
                case (stall_mode)
                    0:       res_bus.ready <= 1'b1;
                    1:       res_bus.ready <= ($urandom_range(0, 3) != 0);
                    2:       res_bus.ready <= ($urandom_range(0, 3) == 0);
                    default: res_bus.ready <= ~res_bus.ready;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, random phases, final drain.
    // ------------------------------------------------------------------------
    initial begin
        t_row        row;
        int          phase;
        int          done_items;
        t_req_kind   kind;
        logic [22:0] step;
        logic [24:0] speed_val;
        logic [24:0] half_x_val;
        logic [24:0] half_y_val;

        rst_n                <= 1'b0;
        req_bus.valid        <= 1'b0;
        req_bus.req_type     <= REQ_TICK;
        req_bus.time_step    <= '0;
        req_bus.launch_speed <= '0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.index        <= bbps_pkg::CFG_PLAY_SPEED;
        cfg_bus.data         <= '0;

        // The predictor starts from the reset state of the core.
        ball_cfg.play_speed   = bbps_pkg::RST_PLAY_SPEED;
        ball_cfg.world_half_x = bbps_pkg::RST_WORLD_HALF_X;
        ball_cfg.world_half_y = bbps_pkg::RST_WORLD_HALF_Y;
        for (int i = 0; i < 3; i++) begin
            ball_ang[i] = '0;
        end
        launch_ball(3'd2);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Ignored ticks (zero step, just over fifty seconds, largest field
        // value) leave the reset pose untouched. A restart at speed zero puts
        // the ball back on the same launch point with its angle still zero.
        add_row(ROW_TICK, 25'd0, 1'b1, RESET_POSE);
        add_row(ROW_TICK, 25'd3276801, 1'b1, RESET_POSE);
        add_row(ROW_TICK, 25'd8388607, 1'b1, RESET_POSE);
        add_row(ROW_RESTART, 25'd0, 1'b1, RESET_POSE);
        // Smallest step, then a launch at the default speed with a frame
        // step, one second, two seconds (floor) and fifty seconds (walls).
        add_row(ROW_TICK, 25'd1);
        add_row(ROW_RESTART, 25'd2);
        add_row(ROW_TICK, 25'd1092);
        add_row(ROW_TICK, 25'd65536);
        add_row(ROW_TICK, 25'd131072);
        add_row(ROW_TICK, 25'd3276800);
        // Launch speeds outside the usual range are used as given.
        add_row(ROW_RESTART, 25'd7);
        add_row(ROW_RESTART, 25'd5);
        add_row(ROW_RESTART, 25'd1);
        add_row(ROW_TICK, 25'd32768);
        add_row(ROW_RESTART, 25'd4);
        add_row(ROW_TICK, 25'd3276800);
        // At the largest play speed this step drives the vertical velocity
        // to the most negative value and wraps the ball below the floor, so
        // the bounce has to negate the most negative value.
        add_row(ROW_WRITE, 25'd16777216, 1'b0, '0, bbps_pkg::CFG_PLAY_SPEED);
        add_row(ROW_RESTART, 25'd2);
        add_row(ROW_TICK, 25'd856320);
        add_row(ROW_TICK, 25'd1092);
        // A play speed of zero freezes motion but the collision tests run.
        add_row(ROW_WRITE, 25'd0, 1'b0, '0, bbps_pkg::CFG_PLAY_SPEED);
        add_row(ROW_TICK, 25'd65536);
        add_row(ROW_WRITE, 25'(bbps_pkg::RST_PLAY_SPEED), 1'b0, '0,
                bbps_pkg::CFG_PLAY_SPEED);
        add_row(ROW_RESTART, 25'd3);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.kind == ROW_WRITE) begin
                drain_results();
                write_register(row.index, row.value);
            end else begin
                offer_request(row.kind == ROW_RESTART ? REQ_RESTART : REQ_TICK,
                              row.value[22:0], row.value[2:0], row.typed, row.pose);
            end
        end

        // Random phases. The first keeps the default world, then come the
        // low extremes, the high extremes, a phase with zero and oversized
        // register values, and random settings near the usual operating point.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase != 0) begin
                case (phase)
                    1: begin
                        speed_val  = 25'd1;
                        half_x_val = 25'd65536;
                        half_y_val = 25'd65536;
                    end
                    2: begin
                        speed_val  = 25'd16777216;
                        half_x_val = 25'd8388608;
                        half_y_val = 25'd8388608;
                    end
                    3: begin
                        // Bit 24 is dropped for the world registers, so the
                        // walls collapse to zero width and the floor sits as
                        // low as the register allows.
                        speed_val  = 25'd0;
                        half_x_val = 25'h1000000;
                        half_y_val = 25'h1ffffff;
                    end
                    default: begin
                        if ($urandom_range(0, 3) == 0) begin
                            speed_val = 25'($urandom_range(1, 16777216));
                        end else begin
                            speed_val = 25'($urandom_range(16384, 262144));
                        end
                        half_x_val = 25'($urandom_range(65536, 2097152));
                        half_y_val = 25'($urandom_range(65536, 2097152));
                    end
                endcase
                drain_results();
                write_register(bbps_pkg::CFG_PLAY_SPEED, speed_val);
                write_register(bbps_pkg::CFG_WORLD_HALF_X, half_x_val);
                write_register(bbps_pkg::CFG_WORLD_HALF_Y, half_y_val);
                if (phase == 3) begin
                    write_register(CFG_UNUSED, 25'($urandom()));
                end
            end

            // Only requests that change the ball count toward the phase.
            done_items = 0;
            while (done_items < PHASE_ITEMS) begin
                kind = ($urandom_range(0, 19) == 0) ? REQ_RESTART : REQ_TICK;
                step = pick_step();
                offer_request(kind, step, 3'($urandom_range(0, 7)));
                if (kind == REQ_RESTART ||
                    (step != '0 && step <= bbps_pkg::MAX_STEP_Q)) begin
                    done_items++;
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_poses.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // A hung handshake ends the run here.
    initial begin
        #(TIMEOUT_TIME);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
